>>> sv/pdv_pkg.sv
// Package for the delta variable-byte postings encoder: widths, masks,
// the posting record type and the group helpers. No dependencies.
package pdv_pkg;

	localparam int ID_BITS = 32;
	localparam int ID_W = (ID_BITS >= 32) ? 32 : ID_BITS;
	localparam logic [31:0] ID_MASK = 32'hFFFF_FFFF >> (32 - ID_W);

	localparam logic [7:0] MORE_FLAG = 8'h80;
	localparam logic [6:0] GROUP_MASK = 7'h7F;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [2:0] MAX_GRP = 3'd4;

	typedef logic [2:0] grp_idx_t;

	typedef struct packed {
		logic [31:0] gap;
		logic [31:0] term_count;
		grp_idx_t    gap_top;
		grp_idx_t    cnt_top;
	} posting_t;

	typedef struct packed {
		logic     valid;
		posting_t entry;
	} head_t;

	// Index of the most significant non-zero 7-bit group (zero for a zero value).
	function automatic grp_idx_t top_group(input logic [31:0] v);
		grp_idx_t k;
		if (v[31:28] != '0)
			k = 3'd4;
		else if (v[27:21] != '0)
			k = 3'd3;
		else if (v[20:14] != '0)
			k = 3'd2;
		else if (v[13:7] != '0)
			k = 3'd1;
		else
			k = 3'd0;
		return k;
	endfunction

	// The 7-bit group k of a value, least significant group is 0.
	function automatic logic [6:0] group_of(input logic [31:0] v, input grp_idx_t k);
		logic [6:0] g;
		case (k)
			3'd0: g = v[6:0];
			3'd1: g = v[13:7];
			3'd2: g = v[20:14];
			3'd3: g = v[27:21];
			3'd4: g = {3'b000, v[31:28]};
			default: g = '0;
		endcase
		return g & GROUP_MASK;
	endfunction

endpackage

>>> sv/pdv_front.sv
// Front end of the encoder: takes postings, forms the id gap and the top group
// indices, and writes one record to the queue. Depends on pdv_pkg.
module pdv_front import pdv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic [31:0] doc_id,
	input  logic [31:0] term_count,
	input  logic        list_start,
	input  logic        q_full,
	output logic        full,
	output logic        wr_en,
	output posting_t    wr_data
);

	logic [31:0] previous_id_q;
	logic [31:0] id_m;
	logic [31:0] gap;

	assign full  = q_full;
	assign wr_en = push && !q_full;
	assign id_m  = doc_id & ID_MASK;
	assign gap   = list_start ? id_m : ((id_m - previous_id_q) & ID_MASK);

	always_comb begin
		wr_data.gap        = gap;
		wr_data.term_count = term_count;
		wr_data.gap_top    = top_group(gap);
		wr_data.cnt_top    = top_group(term_count);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			previous_id_q <= '0;
		end else if (wr_en) begin
			previous_id_q <= id_m;
		end
	end

endmodule

>>> sv/pdv_queue.sv
// Short queue of posting records between the front and back ends.
// Depends on pdv_pkg.
module pdv_queue import pdv_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_en,
	input  posting_t wr_data,
	input  logic     rd_en,
	output logic     q_full,
	output head_t    head
);

	posting_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign q_full     = (count_q == QCNT_W'(QDEPTH));
	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (wr_en && !rd_en)
				count_q <= count_q + 1'b1;
			else if (rd_en && !wr_en)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && q_full))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> head.valid)
		else $error("queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");

endmodule

>>> sv/pdv_back.sv
// Back end of the encoder (uses pdv_pkg): walks the head record group by
// group and emits one code byte per cycle to its free or popped output register.
module pdv_back import pdv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  head_t      head,
	output logic       rd_en,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] code_byte,
	output logic       last_byte
);

	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       started_q;
	logic       phase_q;
	grp_idx_t   grp_q;

	logic        adv;
	logic        phase;
	grp_idx_t    k;
	logic [31:0] value;
	logic [7:0]  next_byte;
	logic        next_last;

	assign phase     = started_q ? phase_q : 1'b0;
	assign k         = started_q ? grp_q : head.entry.gap_top;
	assign value     = phase ? head.entry.term_count : head.entry.gap;
	assign next_byte = {1'b0, group_of(value, k)} | ((k != '0) ? MORE_FLAG : 8'h00);
	assign next_last = phase && (k == '0);
	assign adv       = head.valid && (!out_valid_q || pop);
	assign rd_en     = adv && next_last;

	assign empty     = !out_valid_q;
	assign code_byte = byte_q;
	assign last_byte = last_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_q <= next_byte;
			last_q <= next_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			started_q   <= 1'b0;
			phase_q     <= 1'b0;
			grp_q       <= '0;
		end else begin
			if (adv)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;

			if (adv) begin
				if (k != '0) begin
					grp_q     <= k - 1'b1;
					phase_q   <= phase;
					started_q <= 1'b1;
				end else if (!phase) begin
					grp_q     <= head.entry.cnt_top;
					phase_q   <= 1'b1;
					started_q <= 1'b1;
				end else begin
					grp_q     <= '0;
					phase_q   <= 1'b0;
					started_q <= 1'b0;
				end
			end
		end
	end

	a_started_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> head.valid)
		else $error("byte walk in progress without a queued posting");
	a_grp_range: assert property (@(posedge clk) disable iff (!arst_n)
		grp_q <= MAX_GRP)
		else $error("group index out of range");
	a_last_ends_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> !started_q)
		else $error("walk not closed after final byte");

endmodule

>>> sv/postings_delta_vbyte_encoder.sv
// Top level of the delta variable-byte postings encoder.
// Depends on pdv_pkg, pdv_front, pdv_queue and pdv_back.
//
// Use: postings enter through a queue-style port. A transaction is taken at
// a rising edge where push is high and full is low; it carries doc_id,
// term_count and list_start. Encoded bytes leave through a second queue-style
// port: while empty is low, code_byte and last_byte show the oldest waiting
// byte, and a transaction completes at an edge where pop is high as well.
// Each posting yields the id gap and then the term count, each in big-endian
// 7-bit groups with bit 7 set on every byte but the last of that value; the
// final byte of the posting has last_byte set.
// The first byte of a posting passes through the queue memory and then the
// output register. The back end emits one byte per cycle while the output
// register is free or popped; a posting yields 2 to 10 output bytes, and
// the output port sets the sustained rate. A four-entry queue between the
// front and back ends lets postings be taken while earlier ones are emitted.
// Reset clears the previous id to zero, empties the queue and the output
// register. When the receiver stops popping, the output register holds its
// byte, the queue fills, and full rises to hold off further postings.
module postings_delta_vbyte_encoder import pdv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] doc_id,
	input  logic [31:0] term_count,
	input  logic        list_start,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  code_byte,
	output logic        last_byte
);

	// Records travel from the front end into the queue; the back end reads the head.
	logic     q_full;
	logic     wr_en;
	posting_t wr_data;
	logic     rd_en;
	head_t    head;

	pdv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.doc_id     (doc_id),
		.term_count (term_count),
		.list_start (list_start),
		.q_full     (q_full),
		.full       (full),
		.wr_en      (wr_en),
		.wr_data    (wr_data)
	);

	pdv_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.q_full  (q_full),
		.head    (head)
	);

	// The back end pops a record only when its final byte enters the output register.
	pdv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.rd_en     (rd_en),
		.pop       (pop),
		.empty     (empty),
		.code_byte (code_byte),
		.last_byte (last_byte)
	);

endmodule
